[rtl/htpi_pkg.sv]
package htpi_pkg;

  // Field widths of the ports and of the tick-domain state.
  localparam int unsigned CNT_W      = 16;
  localparam int unsigned SETPOINT_W = 16;
  localparam int unsigned GAIN_W     = 56;
  localparam int unsigned GAIN_LO_W  = 28;
  localparam int unsigned GAIN_HI_W  = GAIN_W - GAIN_LO_W;
  localparam int unsigned DUTY_W     = 7;
  localparam int unsigned RPM_W      = 21;
  localparam int unsigned RPM_PROD_W = RPM_W + 1;
  localparam int unsigned ERR_W      = RPM_W + 1;
  localparam int unsigned MAG_E_W    = RPM_W;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = GAIN_W;

  localparam logic [DUTY_W-1:0] DUTY_LIMIT = 7'd100;
  localparam logic [RPM_W-1:0]  RPM_MAX    = {RPM_W{1'b1}};
  localparam logic [CNT_W-1:0]  PULSE_MAX  = {CNT_W{1'b1}};

  // Register values after reset.
  localparam logic [SETPOINT_W-1:0] SETPOINT_RST = 16'd100;
  localparam logic [GAIN_W-1:0]     KP_RST       = 56'd4312196643;
  localparam logic [GAIN_W-1:0]     KI_TS_RST    = 56'd141;
  localparam logic [CNT_W-1:0]      WINDOW_RST   = 16'd2000;
  localparam logic [CNT_W-1:0]      CONTROL_RST  = 16'd20;
  localparam logic [DUTY_W-1:0]     DUTY_MAX_RST = 7'd100;
  localparam logic [DUTY_W-1:0]     DUTY_MIN_RST = 7'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SETPOINT = 3'd0,
    CFG_KP       = 3'd1,
    CFG_KI_TS    = 3'd2,
    CFG_WINDOW   = 3'd3,
    CFG_CONTROL  = 3'd4,
    CFG_DUTY_MAX = 3'd5,
    CFG_DUTY_MIN = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [SETPOINT_W-1:0] setpoint_rpm;
    logic [GAIN_W-1:0]     kp_gain;
    logic [GAIN_W-1:0]     ki_ts_gain;
    logic [CNT_W-1:0]      window_ticks;
    logic [CNT_W-1:0]      control_ticks;
    logic [DUTY_W-1:0]     duty_max;
    logic [DUTY_W-1:0]     duty_min;
  } cfg_t;

endpackage

[rtl/htpi_cfg_regs.sv]
module htpi_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [htpi_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [htpi_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output htpi_pkg::cfg_t                      cfg_o
);
  import htpi_pkg::*;

  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  // Each word is truncated to the width of the register it targets.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.setpoint_rpm  <= SETPOINT_RST;
      cfg_q.kp_gain       <= KP_RST;
      cfg_q.ki_ts_gain    <= KI_TS_RST;
      cfg_q.window_ticks  <= WINDOW_RST;
      cfg_q.control_ticks <= CONTROL_RST;
      cfg_q.duty_max      <= DUTY_MAX_RST;
      cfg_q.duty_min      <= DUTY_MIN_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_SETPOINT: cfg_q.setpoint_rpm  <= cfg_data_i[SETPOINT_W-1:0];
        CFG_KP:       cfg_q.kp_gain       <= cfg_data_i[GAIN_W-1:0];
        CFG_KI_TS:    cfg_q.ki_ts_gain    <= cfg_data_i[GAIN_W-1:0];
        CFG_WINDOW:   cfg_q.window_ticks  <= cfg_data_i[CNT_W-1:0];
        CFG_CONTROL:  cfg_q.control_ticks <= cfg_data_i[CNT_W-1:0];
        CFG_DUTY_MAX: cfg_q.duty_max      <= cfg_data_i[DUTY_W-1:0];
        CFG_DUTY_MIN: cfg_q.duty_min      <= cfg_data_i[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

[rtl/htpi_front.sv]
module htpi_front #(
  parameter int unsigned INTEGRAL_BITS = 40
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              accept_i,
  input  logic                              hall_level_i,
  input  htpi_pkg::cfg_t                    cfg_i,
  output logic                              upd_o,
  output logic [htpi_pkg::RPM_W-1:0]        rpm_o,
  output logic [htpi_pkg::ERR_W-1:0]        err_o,
  output logic [INTEGRAL_BITS-1:0]          sum_o
);
  import htpi_pkg::*;

  localparam logic [INTEGRAL_BITS-1:0] SUM_MAX = {1'b0, {(INTEGRAL_BITS-1){1'b1}}};
  localparam logic [INTEGRAL_BITS-1:0] SUM_MIN = {1'b1, {(INTEGRAL_BITS-1){1'b0}}};

  logic                     hall_prev_q;
  logic [CNT_W-1:0]         pulse_q, pulse_d, pulse_base;
  logic [CNT_W-1:0]         win_q, win_d;
  logic [CNT_W-1:0]         ctrl_q, ctrl_d;
  logic [RPM_W-1:0]         rpm_q, rpm_d;
  logic [INTEGRAL_BITS-1:0] sum_q, sum_d;
  logic [CNT_W:0]           win_next, ctrl_next;
  logic                     win_fire, ctrl_fire, rise;
  logic [RPM_PROD_W-1:0]    rpm_prod;
  logic [ERR_W-1:0]         err;
  logic [INTEGRAL_BITS:0]   sum_ext;

  always_comb begin
    win_next  = {1'b0, win_q} + 17'd1;
    win_fire  = win_next >= {1'b0, cfg_i.window_ticks};
    win_d     = win_fire ? '0 : win_next[CNT_W-1:0];

    // Pulses times 60, as 64p - 4p.
    rpm_prod  = (RPM_PROD_W'(pulse_q) << 6) - (RPM_PROD_W'(pulse_q) << 2);
    if (win_fire) begin
      rpm_d = rpm_prod[RPM_W] ? RPM_MAX : rpm_prod[RPM_W-1:0];
    end else begin
      rpm_d = rpm_q;
    end

    // The window closes before this tick's sample is counted.
    pulse_base = win_fire ? '0 : pulse_q;
    rise       = hall_level_i & ~hall_prev_q;
    pulse_d    = (rise && pulse_base != PULSE_MAX) ? pulse_base + 16'd1 : pulse_base;

    ctrl_next = {1'b0, ctrl_q} + 17'd1;
    ctrl_fire = ctrl_next >= {1'b0, cfg_i.control_ticks};
    ctrl_d    = ctrl_fire ? '0 : ctrl_next[CNT_W-1:0];

    err     = ERR_W'(cfg_i.setpoint_rpm) - ERR_W'(rpm_d);
    sum_ext = {sum_q[INTEGRAL_BITS-1], sum_q}
            + {{(INTEGRAL_BITS+1-ERR_W){err[ERR_W-1]}}, err};
    if (!ctrl_fire) begin
      sum_d = sum_q;
    end else if (sum_ext[INTEGRAL_BITS] != sum_ext[INTEGRAL_BITS-1]) begin
      sum_d = sum_ext[INTEGRAL_BITS] ? SUM_MIN : SUM_MAX;
    end else begin
      sum_d = sum_ext[INTEGRAL_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hall_prev_q <= 1'b0;
      pulse_q     <= '0;
      win_q       <= '0;
      ctrl_q      <= '0;
      rpm_q       <= '0;
      sum_q       <= '0;
    end else if (accept_i) begin
      hall_prev_q <= hall_level_i;
      pulse_q     <= pulse_d;
      win_q       <= win_d;
      ctrl_q      <= ctrl_d;
      rpm_q       <= rpm_d;
      sum_q       <= sum_d;
    end
  end

  assign upd_o = ctrl_fire;
  assign rpm_o = rpm_d;
  assign err_o = err;
  assign sum_o = sum_d;

endmodule

[rtl/htpi_pi_pipe.sv]
module htpi_pi_pipe #(
  parameter int unsigned INTEGRAL_BITS  = 40,
  parameter int unsigned GAIN_FRAC_BITS = 48
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  htpi_pkg::cfg_t                    cfg_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              upd_i,
  input  logic [htpi_pkg::RPM_W-1:0]        rpm_i,
  input  logic [htpi_pkg::ERR_W-1:0]        err_i,
  input  logic [INTEGRAL_BITS-1:0]          sum_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [htpi_pkg::DUTY_W-1:0]       pwm_duty_o,
  output logic [htpi_pkg::RPM_W-1:0]        speed_rpm_o,
  output logic                              control_updated_o
);
  import htpi_pkg::*;

  localparam int unsigned SUM_LO_W = INTEGRAL_BITS / 2;
  localparam int unsigned SUM_HI_W = INTEGRAL_BITS - SUM_LO_W;
  localparam int unsigned PKL_W    = GAIN_LO_W + MAG_E_W;
  localparam int unsigned PKH_W    = GAIN_HI_W + MAG_E_W;
  localparam int unsigned PLL_W    = GAIN_LO_W + SUM_LO_W;
  localparam int unsigned PLH_W    = GAIN_LO_W + SUM_HI_W;
  localparam int unsigned PHL_W    = GAIN_HI_W + SUM_LO_W;
  localparam int unsigned PHH_W    = GAIN_HI_W + SUM_HI_W;
  localparam int unsigned PK_W     = GAIN_W + MAG_E_W;
  localparam int unsigned PI_W     = GAIN_W + INTEGRAL_BITS;
  localparam int unsigned ACC_W    = PI_W + 2;

  // Stage 1: error and integral as left by the tick.
  logic                     s1_v_q, s1_upd_q;
  logic [RPM_W-1:0]         s1_rpm_q;
  logic [ERR_W-1:0]         s1_err_q;
  logic [INTEGRAL_BITS-1:0] s1_sum_q;
  // Stage 2: sign and magnitude.
  logic                     s2_v_q, s2_upd_q, s2_neg_e_q, s2_neg_s_q;
  logic [RPM_W-1:0]         s2_rpm_q;
  logic [MAG_E_W-1:0]       s2_mag_e_q;
  logic [INTEGRAL_BITS-1:0] s2_mag_s_q;
  // Stage 3: partial products.
  logic                     s3_v_q, s3_upd_q, s3_neg_e_q, s3_neg_s_q;
  logic [RPM_W-1:0]         s3_rpm_q;
  logic [PKL_W-1:0]         s3_pkl_q;
  logic [PKH_W-1:0]         s3_pkh_q;
  logic [PLL_W-1:0]         s3_pll_q;
  logic [PLH_W-1:0]         s3_plh_q;
  logic [PHL_W-1:0]         s3_phl_q;
  logic [PHH_W-1:0]         s3_phh_q;
  // Stage 4: product magnitudes.
  logic                     s4_v_q, s4_upd_q, s4_neg_e_q, s4_neg_s_q;
  logic [RPM_W-1:0]         s4_rpm_q;
  logic [PK_W-1:0]          s4_mk_q;
  logic [PI_W-1:0]          s4_mi_q;
  // Stage 5: signed accumulator.
  logic                     s5_v_q, s5_upd_q;
  logic [RPM_W-1:0]         s5_rpm_q;
  logic [ACC_W-1:0]         s5_acc_q;
  // Result register and the duty state.
  logic                     out_v_q, out_upd_q;
  logic [RPM_W-1:0]         out_rpm_q;
  logic [DUTY_W-1:0]        out_duty_q;
  logic [DUTY_W-1:0]        duty_q;

  logic s1_rdy, s2_rdy, s3_rdy, s4_rdy, s5_rdy, out_rdy;

  logic [ERR_W-1:0]         err_neg;
  logic [INTEGRAL_BITS-1:0] sum_neg;
  logic [ACC_W-1:0]         acc_kp, acc_ki, acc_d;
  logic [ACC_W-1:0]         kmax, kmin;
  logic [DUTY_W-1:0]        duty_clamp, duty_lim, duty_new;

  // A stage takes a word when it is empty or its word moves on.
  assign out_rdy    = !out_v_q || out_ready_i;
  assign s5_rdy     = !s5_v_q || out_rdy;
  assign s4_rdy     = !s4_v_q || s5_rdy;
  assign s3_rdy     = !s3_v_q || s4_rdy;
  assign s2_rdy     = !s2_v_q || s3_rdy;
  assign s1_rdy     = !s1_v_q || s2_rdy;
  assign in_ready_o = s1_rdy;

  always_comb begin
    err_neg = -s1_err_q;
    sum_neg = -s1_sum_q;

    acc_kp = s4_neg_e_q ? -ACC_W'(s4_mk_q) : ACC_W'(s4_mk_q);
    acc_ki = s4_neg_s_q ? -ACC_W'(s4_mi_q) : ACC_W'(s4_mi_q);
    acc_d  = acc_kp + acc_ki;

    // Clamp at full precision; with crossed limits the maximum is checked first, all else takes the minimum.
    kmax = ACC_W'(cfg_i.duty_max) << GAIN_FRAC_BITS;
    kmin = ACC_W'(cfg_i.duty_min) << GAIN_FRAC_BITS;
    priority if ($signed(s5_acc_q) > $signed(kmax)) begin
      duty_clamp = cfg_i.duty_max;
    end else if ($signed(s5_acc_q) < $signed(kmin)) begin
      duty_clamp = cfg_i.duty_min;
    end else begin
      duty_clamp = s5_acc_q[GAIN_FRAC_BITS +: DUTY_W];
    end
    duty_lim = (duty_clamp > DUTY_LIMIT) ? DUTY_LIMIT : duty_clamp;
    duty_new = s5_upd_q ? duty_lim : duty_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      s4_v_q  <= 1'b0;
      s5_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      duty_q  <= '0;
    end else begin
      if (s1_rdy) begin
        s1_v_q <= in_valid_i;
      end
      if (s2_rdy) begin
        s2_v_q <= s1_v_q;
      end
      if (s3_rdy) begin
        s3_v_q <= s2_v_q;
      end
      if (s4_rdy) begin
        s4_v_q <= s3_v_q;
      end
      if (s5_rdy) begin
        s5_v_q <= s4_v_q;
      end
      if (out_rdy) begin
        out_v_q <= s5_v_q;
        if (s5_v_q) begin
          duty_q <= duty_new;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_rdy) begin
      s1_upd_q <= upd_i;
      s1_rpm_q <= rpm_i;
      s1_err_q <= err_i;
      s1_sum_q <= sum_i;
    end
    if (s2_rdy) begin
      s2_upd_q   <= s1_upd_q;
      s2_rpm_q   <= s1_rpm_q;
      s2_neg_e_q <= s1_err_q[ERR_W-1];
      s2_neg_s_q <= s1_sum_q[INTEGRAL_BITS-1];
      s2_mag_e_q <= s1_err_q[ERR_W-1] ? err_neg[MAG_E_W-1:0] : s1_err_q[MAG_E_W-1:0];
      s2_mag_s_q <= s1_sum_q[INTEGRAL_BITS-1] ? sum_neg : s1_sum_q;
    end
    if (s3_rdy) begin
      s3_upd_q   <= s2_upd_q;
      s3_rpm_q   <= s2_rpm_q;
      s3_neg_e_q <= s2_neg_e_q;
      s3_neg_s_q <= s2_neg_s_q;
      s3_pkl_q   <= PKL_W'(cfg_i.kp_gain[GAIN_LO_W-1:0]) * PKL_W'(s2_mag_e_q);
      s3_pkh_q   <= PKH_W'(cfg_i.kp_gain[GAIN_W-1:GAIN_LO_W]) * PKH_W'(s2_mag_e_q);
      s3_pll_q   <= PLL_W'(cfg_i.ki_ts_gain[GAIN_LO_W-1:0])
                  * PLL_W'(s2_mag_s_q[SUM_LO_W-1:0]);
      s3_plh_q   <= PLH_W'(cfg_i.ki_ts_gain[GAIN_LO_W-1:0])
                  * PLH_W'(s2_mag_s_q[INTEGRAL_BITS-1:SUM_LO_W]);
      s3_phl_q   <= PHL_W'(cfg_i.ki_ts_gain[GAIN_W-1:GAIN_LO_W])
                  * PHL_W'(s2_mag_s_q[SUM_LO_W-1:0]);
      s3_phh_q   <= PHH_W'(cfg_i.ki_ts_gain[GAIN_W-1:GAIN_LO_W])
                  * PHH_W'(s2_mag_s_q[INTEGRAL_BITS-1:SUM_LO_W]);
    end
    if (s4_rdy) begin
      s4_upd_q   <= s3_upd_q;
      s4_rpm_q   <= s3_rpm_q;
      s4_neg_e_q <= s3_neg_e_q;
      s4_neg_s_q <= s3_neg_s_q;
      s4_mk_q    <= (PK_W'(s3_pkh_q) << GAIN_LO_W) + PK_W'(s3_pkl_q);
      s4_mi_q    <= (PI_W'(s3_phh_q) << (GAIN_LO_W + SUM_LO_W))
                  + (PI_W'(s3_phl_q) << GAIN_LO_W)
                  + (PI_W'(s3_plh_q) << SUM_LO_W)
                  + PI_W'(s3_pll_q);
    end
    if (s5_rdy) begin
      s5_upd_q <= s4_upd_q;
      s5_rpm_q <= s4_rpm_q;
      s5_acc_q <= acc_d;
    end
    if (out_rdy) begin
      out_upd_q  <= s5_upd_q;
      out_rpm_q  <= s5_rpm_q;
      out_duty_q <= duty_new;
    end
  end

  assign out_valid_o       = out_v_q;
  assign pwm_duty_o        = out_duty_q;
  assign speed_rpm_o       = out_rpm_q;
  assign control_updated_o = out_upd_q;

endmodule

[rtl/hall_tachometer_pi_speed_control.sv]
// Hall tachometer with a clamped PI speed loop. Each input word is one sampling
// tick carrying the sampled Hall level, and each tick yields exactly one result
// word with the current duty, the latest measured speed and a flag for ticks on
// which a PI step ran. A new tick is taken every clock cycle unless the result
// side stalls; each result is computed by the pipelined gain multipliers (gains
// split into 28-bit halves, partial products, product sums, signed accumulate,
// then clamp). Tick counting, speed measurement and the saturating integral
// update happen in the cycle a tick is accepted, so configuration registers are
// only to be written while no tick is in flight.
module hall_tachometer_pi_speed_control #(
  parameter int unsigned INTEGRAL_BITS  = 40,
  parameter int unsigned GAIN_FRAC_BITS = 48
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [htpi_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [htpi_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              hall_level_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [htpi_pkg::DUTY_W-1:0]       pwm_duty_o,
  output logic [htpi_pkg::RPM_W-1:0]        speed_rpm_o,
  output logic                              control_updated_o
);
  import htpi_pkg::*;

  cfg_t                     cfg;
  logic                     upd;
  logic [RPM_W-1:0]         rpm;
  logic [ERR_W-1:0]         err;
  logic [INTEGRAL_BITS-1:0] sum;

  htpi_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  htpi_front #(
    .INTEGRAL_BITS (INTEGRAL_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (in_valid_i && in_ready_o),
    .hall_level_i (hall_level_i),
    .cfg_i        (cfg),
    .upd_o        (upd),
    .rpm_o        (rpm),
    .err_o        (err),
    .sum_o        (sum)
  );

  htpi_pi_pipe #(
    .INTEGRAL_BITS  (INTEGRAL_BITS),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_pipe (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .upd_i             (upd),
    .rpm_i             (rpm),
    .err_i             (err),
    .sum_i             (sum),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .pwm_duty_o        (pwm_duty_o),
    .speed_rpm_o       (speed_rpm_o),
    .control_updated_o (control_updated_o)
  );

`ifndef SYNTHESIS
  // With the result side free, every stage can move, so a tick is always taken.
  a_ready_when_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o || out_ready_i) |-> in_ready_o)
    else $error("input stalled while the result side was free");

  a_duty_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pwm_duty_o <= DUTY_LIMIT)
    else $error("duty above the hard limit");

  // Speed is a pulse count times 60 unless it saturated.
  a_speed_multiple: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((speed_rpm_o % 60) == 0 || speed_rpm_o == RPM_MAX))
    else $error("speed is not a whole number of pulses");
`endif

endmodule
